>>> rtl/core/tdt_pkg.sv
// Shared types, codes and widths for the table-driven DFA tokenizer.
// No dependencies; tdt_resq and the tokenizer top level import this package.
`default_nettype none

package tdt_pkg;

   localparam int DEFAULT_NUM_STATES = 128;
   localparam int DEFAULT_NUM_CHARS  = 128;

   localparam int OP_W       = 2;
   localparam int STATE_W    = 7;
   localparam int CHAR_W     = 7;
   localparam int ENTRY_W    = STATE_W + 1;
   localparam int ATTR_W     = 3;
   localparam int POS_W      = 16;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;
   localparam int RESQ_DEPTH = 4;

   localparam logic [POS_W-1:0] POS_MAX = '1;

   localparam logic [OP_W-1:0] OP_WRITE_TRANS = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE_ATTR  = 2'd1;
   localparam logic [OP_W-1:0] OP_FEED        = 2'd2;

   localparam logic [1:0] ACT_SKIP   = 2'd1;
   localparam logic [1:0] ACT_RETURN = 2'd2;

   localparam logic [STATUS_W-1:0] ST_TOKEN      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_ACTION = 2'd1;
   localparam logic [STATUS_W-1:0] ST_REJECT     = 2'd2;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [STATE_W-1:0]  kind;
      logic [POS_W-1:0]    start;
      logic [POS_W-1:0]    length;
      logic                last;
   } tdt_result_type;

   typedef struct packed {
      logic           v0;
      logic           v1;
      tdt_result_type r0;
      tdt_result_type r1;
   } tdt_push_type;

   typedef struct packed {
      logic                emit;
      logic                halt;
      logic [STATUS_W-1:0] status;
   } tdt_close_type;

   function automatic tdt_close_type tdt_close(input logic [ATTR_W-1:0] attr);
      tdt_close_type res;
      res = '0;
      if (!attr[0]) begin
         res.emit   = 1'b1;
         res.halt   = 1'b1;
         res.status = ST_REJECT;
      end else begin
         case (attr[2:1])
            ACT_RETURN: begin
               res.emit   = 1'b1;
               res.status = ST_TOKEN;
            end
            ACT_SKIP: begin
               res.emit = 1'b0;
            end
            default: begin
               res.emit   = 1'b1;
               res.status = ST_BAD_ACTION;
            end
         endcase
      end
      return res;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/tdt_ram.sv
// Generic synchronous RAM with one write port and two registered read ports.
// Standalone; used for the transition table and the state attribute store.
`default_nettype none

module tdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

>>> rtl/core/tdt_resq.sv
// Result queue of the tokenizer: takes up to two results per cycle, hands out one when out_ready is high.
// Depends on tdt_pkg for the result and push types and the queue depth.
`default_nettype none

module tdt_resq (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire tdt_pkg::tdt_push_type                 push,
   output logic                                       out_valid,
   input  wire logic                                  out_ready,
   output tdt_pkg::tdt_result_type                    out_data,
   output logic [$clog2(tdt_pkg::RESQ_DEPTH):0]       level
);

   import tdt_pkg::*;

   localparam int PW = $clog2(RESQ_DEPTH);

   tdt_result_type entry_ff [RESQ_DEPTH];
   logic [PW-1:0]  wr_ff;
   logic [PW-1:0]  wr_in;
   logic [PW-1:0]  rd_ff;
   logic [PW-1:0]  rd_in;
   logic [PW:0]    count_ff;
   logic [PW:0]    count_in;
   logic           pop;
   logic [PW-1:0]  wr_next;

   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ff];
   assign level     = count_ff;
   assign pop       = out_valid && out_ready;
   assign wr_next   = wr_ff + PW'(1);

   always_comb begin
      wr_in    = wr_ff + PW'(push.v0) + PW'(push.v1);
      rd_in    = rd_ff + PW'(pop);
      count_in = count_ff + (PW+1)'(push.v0) + (PW+1)'(push.v1) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.v0) begin
         entry_ff[wr_ff] <= push.r0;
      end
      if (push.v1) begin
         entry_ff[wr_next] <= push.r1;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/table_driven_dfa_tokenizer.sv
// Programmable DFA lexer with longest-match tokenizing. After reset the block runs a clearing
// pass over the transition and attribute memories, one entry per cycle, until every entry is
// zero, with req_tready low. Table and attribute beats are then written as they are accepted,
// so they can follow back to back while the queue has room. A fed character is first looked up
// in the transition and attribute memories (current state and start state read in parallel)
// and then resolved; req_tready stays low while it resolves, since the next character's lookup
// address is the state that this resolve produces. Results wait in a four-entry queue; input is
// held off while more than two results are waiting, so a stalled result side holds up input
// once three results are queued. One character yields at most two result beats.
// Depends on tdt_pkg, tdt_ram and tdt_resq.
`default_nettype none

module table_driven_dfa_tokenizer #(
   parameter int NUM_STATES = tdt_pkg::DEFAULT_NUM_STATES,
   parameter int NUM_CHARS  = tdt_pkg::DEFAULT_NUM_CHARS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // state_index, char_code, next_valid, next_state, accepting_flag, action_code
   input  wire logic [tdt_pkg::REQ_DATA_W-1:0]    req_tdata,
   // opcode
   input  wire logic [tdt_pkg::OP_W-1:0]          req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // token_kind, token_start, token_length
   output logic      [tdt_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // status
   output logic      [tdt_pkg::STATUS_W-1:0]      rsp_tuser,
   output logic                                   rsp_tlast
);

   import tdt_pkg::*;

   localparam int SAW = $clog2(NUM_STATES);
   localparam int CAW = $clog2(NUM_CHARS);
   localparam int TAW = SAW + CAW;

   logic [STATE_W-1:0] in_si;
   logic [CHAR_W-1:0]  in_ch;
   logic               in_nv;
   logic [STATE_W-1:0] in_ns;
   logic               in_acc;
   logic [1:0]         in_act;
   logic               accept;
   logic               si_ok;
   logic               ch_ok;

   logic               clear_ff;
   logic [TAW-1:0]     sweep_ff;
   logic               resolve_ff;
   logic [CHAR_W-1:0]  c_ff;
   logic [STATE_W-1:0] cur_ff;
   logic [STATE_W-1:0] cur_in;
   logic [POS_W-1:0]   begin_ff;
   logic [POS_W-1:0]   begin_in;
   logic [POS_W-1:0]   pos_ff;
   logic [POS_W-1:0]   pos_in;
   logic               halted_ff;
   logic               halted_in;

   logic               t_we;
   logic [TAW-1:0]     t_waddr;
   logic [ENTRY_W-1:0] t_wdata;
   logic [ENTRY_W-1:0] e_cur;
   logic [ENTRY_W-1:0] e_zero;
   logic               a_we;
   logic [SAW-1:0]     a_waddr;
   logic [ATTR_W-1:0]  a_wdata;
   logic [ATTR_W-1:0]  a_cur;
   logic [ATTR_W-1:0]  a_zero;

   tdt_push_type       push;
   tdt_result_type     head;
   logic [$clog2(RESQ_DEPTH):0] level;

   tdt_close_type      cl_cur;
   tdt_close_type      cl_zero;
   tdt_result_type     res_cur;
   tdt_result_type     res_zero;
   logic               c_in_range;
   logic               hit_cur;
   logic               hit_zero;
   logic               inprog;
   logic [POS_W-1:0]   pos_adv;
   logic               emit_cur;
   logic               emit_zero;

   assign in_si  = req_tdata[6:0];
   assign in_ch  = req_tdata[13:7];
   assign in_nv  = req_tdata[14];
   assign in_ns  = req_tdata[21:15];
   assign in_acc = req_tdata[22];
   assign in_act = req_tdata[24:23];

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !clear_ff && !resolve_ff && (int'(level) <= RESQ_DEPTH - 2);
   assign si_ok      = int'(in_si) < NUM_STATES;
   assign ch_ok      = int'(in_ch) < NUM_CHARS;

   // Memory write ports: the clearing pass, then table and attribute beats.
   always_comb begin
      t_we    = 1'b0;
      t_waddr = {SAW'(in_si), CAW'(in_ch)};
      t_wdata = (in_nv && int'(in_ns) < NUM_STATES) ? {1'b1, in_ns} : '0;
      a_we    = 1'b0;
      a_waddr = SAW'(in_si);
      a_wdata = {in_act, in_acc};
      if (clear_ff) begin
         t_we    = 1'b1;
         t_waddr = sweep_ff;
         t_wdata = '0;
         a_we    = 1'b1;
         a_waddr = sweep_ff[SAW-1:0];
         a_wdata = '0;
      end else if (accept) begin
         case (req_tuser)
            OP_WRITE_TRANS: begin
               t_we = si_ok && ch_ok;
            end
            OP_WRITE_ATTR: begin
               a_we = si_ok;
            end
            default: begin
               t_we = 1'b0;
               a_we = 1'b0;
            end
         endcase
      end
   end

   tdt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (2**TAW)
   ) u_trans (
      .clock     (clock),
      .wr_en     (t_we),
      .wr_addr   (t_waddr),
      .wr_data   (t_wdata),
      .rd_addr_a ({SAW'(cur_ff), CAW'(in_ch)}),
      .rd_addr_b ({SAW'(0), CAW'(in_ch)}),
      .rd_data_a (e_cur),
      .rd_data_b (e_zero)
   );

   tdt_ram #(
      .WIDTH (ATTR_W),
      .DEPTH (2**SAW)
   ) u_attr (
      .clock     (clock),
      .wr_en     (a_we),
      .wr_addr   (a_waddr),
      .wr_data   (a_wdata),
      .rd_addr_a (SAW'(cur_ff)),
      .rd_addr_b (SAW'(0)),
      .rd_data_a (a_cur),
      .rd_data_b (a_zero)
   );

   // Resolve: the character's lookup data is back from both memories.
   always_comb begin
      c_in_range = int'(c_ff) < NUM_CHARS;
      hit_cur    = e_cur[ENTRY_W-1] && c_in_range;
      hit_zero   = e_zero[ENTRY_W-1] && c_in_range;
      inprog     = (cur_ff != '0) || (pos_ff != begin_ff);
      pos_adv    = (pos_ff == POS_MAX) ? pos_ff : pos_ff + POS_W'(1);
      cl_cur     = tdt_close(a_cur);
      cl_zero    = tdt_close(a_zero);

      res_cur.status  = cl_cur.status;
      res_cur.kind    = cur_ff;
      res_cur.start   = begin_ff;
      res_cur.length  = pos_ff - begin_ff;
      res_cur.last    = 1'b1;
      res_zero.status = cl_zero.status;
      res_zero.kind   = '0;
      res_zero.start  = pos_ff;
      res_zero.length = '0;
      res_zero.last   = 1'b1;

      cur_in    = cur_ff;
      begin_in  = begin_ff;
      pos_in    = pos_ff;
      halted_in = halted_ff;
      emit_cur  = 1'b0;
      emit_zero = 1'b0;

      if (resolve_ff) begin
         if (c_ff == '0) begin
            emit_cur  = !halted_ff && inprog && cl_cur.emit;
            cur_in    = '0;
            begin_in  = '0;
            pos_in    = '0;
            halted_in = 1'b0;
         end else if (!halted_ff) begin
            if (hit_cur) begin
               cur_in = e_cur[STATE_W-1:0];
               pos_in = pos_adv;
            end else begin
               emit_cur = inprog && cl_cur.emit;
               if (inprog && cl_cur.halt) begin
                  halted_in = 1'b1;
               end else begin
                  begin_in = pos_ff;
                  cur_in   = '0;
                  if (hit_zero) begin
                     cur_in = e_zero[STATE_W-1:0];
                     pos_in = pos_adv;
                  end else begin
                     emit_zero = cl_zero.emit;
                     if (cl_zero.halt) begin
                        halted_in = 1'b1;
                     end else begin
                        pos_in   = pos_adv;
                        begin_in = pos_adv;
                     end
                  end
               end
            end
         end
      end

      push    = '0;
      push.v0 = emit_cur || emit_zero;
      push.v1 = emit_cur && emit_zero;
      push.r0 = emit_cur ? res_cur : res_zero;
      push.r1 = res_zero;
      if (emit_cur && emit_zero) begin
         push.r0.last = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff   <= 1'b1;
         sweep_ff   <= '0;
         resolve_ff <= 1'b0;
         cur_ff     <= '0;
         begin_ff   <= '0;
         pos_ff     <= '0;
         halted_ff  <= 1'b0;
      end else begin
         if (clear_ff) begin
            sweep_ff <= sweep_ff + TAW'(1);
            if (sweep_ff == '1) begin
               clear_ff <= 1'b0;
            end
         end
         resolve_ff <= accept && (req_tuser == OP_FEED);
         cur_ff     <= cur_in;
         begin_ff   <= begin_in;
         pos_ff     <= pos_in;
         halted_ff  <= halted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         c_ff <= in_ch;
      end
   end

   tdt_resq u_resq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (head),
      .level     (level)
   );

   assign rsp_tdata = {1'b0, head.length, head.start, head.kind};
   assign rsp_tuser = head.status;
   assign rsp_tlast = head.last;

   a_resolve_after_feed: assert property (@(posedge clock) disable iff (reset)
      resolve_ff |-> $past(accept && (req_tuser == OP_FEED)))
      else $error("Resolve cycle without a character beat before it.");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      int'(level) <= RESQ_DEPTH)
      else $error("Result queue overflow.");

   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      (resolve_ff && halted_ff && (c_ff != '0)) |-> !push.v0)
      else $error("Result produced while halted.");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      push.v1 |-> (push.v0 && resolve_ff && !push.r0.last))
      else $error("Second result without a first one.");

endmodule

`default_nettype wire
